/* sv/calendar_seconds_converter_defines.svh */
// Assertion macros for the calendar seconds converter.
`ifndef CALENDAR_SECONDS_CONVERTER_DEFINES_SVH
`define CALENDAR_SECONDS_CONVERTER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define CSC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CSC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/csc_pkg.sv */
// Shared types, constants and table functions of the calendar seconds converter.
package csc_pkg;

	localparam int unsigned ACC_W = 34;
	localparam logic [11:0] BASE_YEAR_RST = 12'd2000;
	localparam logic [7:0]  YEAR_LIMIT = 8'd135;
	localparam logic [7:0]  YEAR_WALK_MAX = 8'd255;
	localparam logic [3:0]  FIRST_MONTH = 4'd1;
	localparam logic [3:0]  LAST_MONTH = 4'd12;
	localparam logic [4:0]  MAX_HOUR = 5'd23;
	localparam logic [5:0]  MAX_MIN_SEC = 6'd59;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN = 6'd60;
	localparam logic [8:0]  LEAP_CYCLE = 9'd400;
	localparam logic [8:0]  LEAP_CYCLE_LAST = 9'd399;
	localparam logic [31:0] SECS_YEAR = 32'd31536000;
	localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BMOD,
		ST_DMIN,
		ST_DHOUR,
		ST_DDAY,
		ST_DYEAR,
		ST_DMON,
		ST_SYEAR,
		ST_SMON,
		ST_SDAY,
		ST_SHOUR,
		ST_SMIN,
		ST_FIN
	} state_t;

	typedef enum logic {
		REQ_TO_SECS = 1'b0,
		REQ_TO_DATE = 1'b1
	} req_t;

	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
		logic             sub;
	} alu_op_t;

	typedef struct packed {
		req_t        req;
		logic [31:0] seconds;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} request_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        invalid;
	} result_t;

	// c is the year modulo 400
	function automatic logic is_leap(input logic [8:0] c);
		return (c[1:0] == 2'd0) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
	endfunction

	function automatic logic [31:0] year_secs(input logic leap);
		return leap ? SECS_LEAP_YEAR : SECS_YEAR;
	endfunction

	function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
		logic [31:0] s;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: s = 32'd2678400;
			4'd4, 4'd6, 4'd9, 4'd11:                    s = 32'd2592000;
			4'd2:                                       s = leap ? 32'd2505600 : 32'd2419200;
			default:                                    s = 32'd0;
		endcase
		return s;
	endfunction

endpackage

/* sv/csc_alu.sv */
// Shared add/subtract unit with borrow flag.
module csc_alu (
	input  csc_pkg::alu_op_t          op,
	output logic [csc_pkg::ACC_W-1:0] res,
	output logic                      borrow
);
	import csc_pkg::*;

	logic [ACC_W:0] full;

	always_comb begin
		if (op.sub) begin
			full = {1'b0, op.a} - {1'b0, op.b};
		end else begin
			full = {1'b0, op.a} + {1'b0, op.b};
		end
		res    = full[ACC_W-1:0];
		borrow = op.sub & full[ACC_W];
	end

endmodule

/* sv/csc_ctrl.sv */
// Sequencer and working registers driving the shared add/subtract unit.
`include "calendar_seconds_converter_defines.svh"

module csc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [11:0]        base_year,
	input  logic               req_valid,
	output logic               req_ready,
	input  csc_pkg::request_t  req,
	output logic               res_valid,
	input  logic               res_ready,
	output csc_pkg::result_t   res
);
	import csc_pkg::*;

	state_t           state_q, state_d;
	req_t             dir_q, dir_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [11:0]      c400_q, c400_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [3:0]       mon_q, mon_d;
	logic [2:0]       bit_q, bit_d;
	logic [4:0]       qday_q, qday_d;
	logic [4:0]       qhour_q, qhour_d;
	logic [5:0]       qmin_q, qmin_d;
	logic             inval_q, inval_d;

	logic [7:0]       year_q;
	logic [3:0]       month_q;
	logic [4:0]       day_q;
	logic [4:0]       hour_q;
	logic [5:0]       minute_q;

	alu_op_t          op;
	logic [ACC_W-1:0] alu_res;
	logic             borrow;
	logic             leap;
	logic [11:0]      c400_next;
	logic             bad_date;

	csc_alu u_alu (
		.op     (op),
		.res    (alu_res),
		.borrow (borrow)
	);

	assign leap      = is_leap(c400_q[8:0]);
	assign c400_next = (c400_q[8:0] == LEAP_CYCLE_LAST) ? 12'd0 : c400_q + 12'd1;
	assign bad_date  = (req.year > YEAR_LIMIT) || (req.month < FIRST_MONTH) ||
		(req.month > LAST_MONTH) || (req.day == 5'd0) || (req.hour > MAX_HOUR) ||
		(req.minute > MAX_MIN_SEC) || (req.second > MAX_MIN_SEC);

	always_comb begin
		op.a   = acc_q;
		op.b   = '0;
		op.sub = 1'b0;
		unique case (state_q)
			ST_BMOD: begin
				op.a   = ACC_W'(c400_q);
				op.b   = ACC_W'(LEAP_CYCLE) << bit_q;
				op.sub = 1'b1;
			end
			ST_DMIN:  op.b = ACC_W'(minute_q) * ACC_W'(SECS_PER_MIN);
			ST_DHOUR: op.b = ACC_W'(hour_q) * ACC_W'(SECS_PER_HOUR);
			ST_DDAY:  op.b = ACC_W'(day_q - 5'd1) * ACC_W'(SECS_PER_DAY);
			ST_DYEAR: op.b = ACC_W'(year_secs(leap));
			ST_DMON:  op.b = ACC_W'(month_secs(mon_q, leap));
			ST_SYEAR: begin
				op.b   = ACC_W'(year_secs(leap));
				op.sub = 1'b1;
			end
			ST_SMON: begin
				op.b   = ACC_W'(month_secs(mon_q, leap));
				op.sub = 1'b1;
			end
			ST_SDAY: begin
				op.b   = ACC_W'(SECS_PER_DAY) << bit_q;
				op.sub = 1'b1;
			end
			ST_SHOUR: begin
				op.b   = ACC_W'(SECS_PER_HOUR) << bit_q;
				op.sub = 1'b1;
			end
			ST_SMIN: begin
				op.b   = ACC_W'(SECS_PER_MIN) << bit_q;
				op.sub = 1'b1;
			end
			default: begin
				op.b = '0;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		dir_d     = dir_q;
		acc_d     = acc_q;
		c400_d    = c400_q;
		cnt_d     = cnt_q;
		mon_d     = mon_q;
		bit_d     = bit_q;
		qday_d    = qday_q;
		qhour_d   = qhour_q;
		qmin_d    = qmin_q;
		inval_d   = inval_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					dir_d   = req.req;
					c400_d  = base_year;
					cnt_d   = '0;
					mon_d   = FIRST_MONTH;
					bit_d   = 3'd3;
					qday_d  = '0;
					qhour_d = '0;
					qmin_d  = '0;
					inval_d = 1'b0;
					if (req.req == REQ_TO_SECS) begin
						acc_d = ACC_W'(req.second);
						if (bad_date) begin
							inval_d = 1'b1;
							state_d = ST_FIN;
						end else begin
							state_d = ST_BMOD;
						end
					end else begin
						acc_d   = ACC_W'(req.seconds);
						state_d = ST_BMOD;
					end
				end
			end
			ST_BMOD: begin
				if (!borrow) begin
					c400_d = alu_res[11:0];
				end
				if (bit_q == 3'd0) begin
					state_d = (dir_q == REQ_TO_SECS) ? ST_DMIN : ST_SYEAR;
				end else begin
					bit_d = bit_q - 3'd1;
				end
			end
			ST_DMIN: begin
				acc_d   = alu_res;
				state_d = ST_DHOUR;
			end
			ST_DHOUR: begin
				acc_d   = alu_res;
				state_d = ST_DDAY;
			end
			ST_DDAY: begin
				acc_d   = alu_res;
				state_d = ST_DYEAR;
			end
			ST_DYEAR: begin
				if (cnt_q == year_q) begin
					state_d = ST_DMON;
				end else begin
					acc_d  = alu_res;
					cnt_d  = cnt_q + 8'd1;
					c400_d = c400_next;
				end
			end
			ST_DMON: begin
				if (mon_q == month_q) begin
					inval_d = |acc_q[ACC_W-1:32];
					state_d = ST_FIN;
				end else begin
					acc_d = alu_res;
					mon_d = mon_q + 4'd1;
				end
			end
			ST_SYEAR: begin
				if (cnt_q == YEAR_WALK_MAX || borrow) begin
					state_d = ST_SMON;
				end else begin
					acc_d  = alu_res;
					cnt_d  = cnt_q + 8'd1;
					c400_d = c400_next;
				end
			end
			ST_SMON: begin
				if (mon_q == LAST_MONTH || borrow) begin
					bit_d   = 3'd4;
					state_d = ST_SDAY;
				end else begin
					acc_d = alu_res;
					mon_d = mon_q + 4'd1;
				end
			end
			ST_SDAY: begin
				if (!borrow) begin
					acc_d          = alu_res;
					qday_d[bit_q]  = 1'b1;
				end
				if (bit_q == 3'd0) begin
					bit_d   = 3'd4;
					state_d = ST_SHOUR;
				end else begin
					bit_d = bit_q - 3'd1;
				end
			end
			ST_SHOUR: begin
				if (!borrow) begin
					acc_d          = alu_res;
					qhour_d[bit_q] = 1'b1;
				end
				if (bit_q == 3'd0) begin
					bit_d   = 3'd5;
					state_d = ST_SMIN;
				end else begin
					bit_d = bit_q - 3'd1;
				end
			end
			ST_SMIN: begin
				if (!borrow) begin
					acc_d         = alu_res;
					qmin_d[bit_q] = 1'b1;
				end
				if (bit_q == 3'd0) begin
					state_d = ST_FIN;
				end else begin
					bit_d = bit_q - 3'd1;
				end
			end
			ST_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res = '0;
		if (dir_q == REQ_TO_SECS) begin
			res.invalid = inval_q;
			res.seconds = inval_q ? 32'd0 : acc_q[31:0];
		end else begin
			res.year   = cnt_q;
			res.month  = mon_q;
			res.day    = qday_q + 5'd1;
			res.hour   = qhour_q;
			res.minute = qmin_q;
			res.second = acc_q[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dir_q   <= REQ_TO_SECS;
			inval_q <= 1'b0;
			bit_q   <= '0;
			cnt_q   <= '0;
			mon_q   <= FIRST_MONTH;
			c400_q  <= '0;
		end else begin
			state_q <= state_d;
			dir_q   <= dir_d;
			inval_q <= inval_d;
			bit_q   <= bit_d;
			cnt_q   <= cnt_d;
			mon_q   <= mon_d;
			c400_q  <= c400_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q   <= acc_d;
		qday_q  <= qday_d;
		qhour_q <= qhour_d;
		qmin_q  <= qmin_d;
		if (state_q == ST_IDLE && req_valid) begin
			year_q   <= req.year;
			month_q  <= req.month;
			day_q    <= req.day;
			hour_q   <= req.hour;
			minute_q <= req.minute;
		end
	end

	`CSC_ASSERT(a_leap_ctr_range, (state_q == ST_DYEAR || state_q == ST_DMON || state_q == ST_SYEAR || state_q == ST_SMON) |-> (c400_q < 12'(LEAP_CYCLE)), "leap cycle counter out of range")
	`CSC_ASSERT(a_day_rem_range, (state_q == ST_SDAY && bit_q == 3'd4) |-> (acc_q < (ACC_W'(SECS_PER_DAY) << 5)), "month remainder too large")
	`CSC_ASSERT_NEXT(a_fin_hold, state_q == ST_FIN && !res_ready, state_q == ST_FIN && $stable(res), "result dropped before transfer")

endmodule

/* sv/calendar_seconds_converter.sv */
// Top level of the calendar seconds converter: stream ports, base year register, output register.
// Date to seconds adds minutes, hours, days, then each year and month; a bad date ends at once.
// Seconds to date subtracts years, then months, then day, hour and minute quotient bits.
// One shared 34-bit add/subtract unit sets the rate: one year, month or quotient bit per cycle.
// One item at a time; next taken the cycle after the result is registered, even while it waits.
// arst_n clears all control state and loads base_year with 2000.
module calendar_seconds_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// seconds_in[31:0], year_in[39:32], month_in[43:40], day_in[48:44],
	// hour_in[53:49], minute_in[59:54], second_in[65:60], zero pad
	input  logic [71:0] s_tdata,
	// req_type[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// seconds_out[31:0], year_out[39:32], month_out[43:40], day_out[48:44],
	// hour_out[53:49], minute_out[59:54], second_out[65:60], zero pad
	output logic [71:0] m_tdata,
	// invalid[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);
	import csc_pkg::*;

	logic [11:0] base_year_q;
	request_t    req;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;
	logic        res_valid;
	logic        res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q <= BASE_YEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			base_year_q <= cfg_data;
		end
	end

	always_comb begin
		req.req     = req_t'(s_tuser[0]);
		req.seconds = s_tdata[31:0];
		req.year    = s_tdata[39:32];
		req.month   = s_tdata[43:40];
		req.day     = s_tdata[48:44];
		req.hour    = s_tdata[53:49];
		req.minute  = s_tdata[59:54];
		req.second  = s_tdata[65:60];
	end

	csc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_year (base_year_q),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.second, out_q.minute, out_q.hour, out_q.day,
		out_q.month, out_q.year, out_q.seconds};
	assign m_tuser  = out_q.invalid;

endmodule
